>>> sv/csd_pkg.sv
// Shared constants, widths and the exp2 factor table for the cascade split block.
// Depends on nothing; the top level and its checker import it.
package csd_pkg;

   localparam int MAX_CASCADES_DEF = 4;
   localparam int CNT_W            = 4;
   localparam int DIST_W           = 32;
   localparam int COUNT_W          = 8;
   localparam int FRAC_W           = 17;
   localparam int INDEX_W          = 3;
   localparam int REQ_DATA_W       = 96;
   localparam int RSP_DATA_W       = 24;
   localparam int LOG_FRAC_W       = 24;

   localparam logic [FRAC_W-1:0] SPLIT_ONE  = 17'h10000;
   localparam logic [DIST_W-1:0] NEAR_MIN   = 32'd7;
   localparam logic [DIST_W-1:0] NEAR_MAX   = 32'hFFFF_FFF8;
   localparam logic [DIST_W-1:0] FAR_MARGIN = 32'd7;

   // Digit-serial multiplier: 32 by 32 bits, four multiplier bits per cycle.
   localparam int MUL_W     = 32;
   localparam int MUL_DIGIT = 4;
   localparam int MUL_STEPS = MUL_W / MUL_DIGIT;
   localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);

   // Bit-serial restoring divider: up to 80 dividend bits, 47-bit divisor.
   localparam int DIV_W     = 80;
   localparam int DVS_W     = 47;
   localparam int Q_W       = 32;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   typedef logic [LOG_FRAC_W-1:0][31:0] factor_tab_type;

   // Truncated integer square root, evaluated only while building the table.
   function automatic logic [63:0] isqrt64(input logic [63:0] value);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bitv;
      v    = value;
      res  = '0;
      bitv = 64'h4000_0000_0000_0000;
      for (int s = 0; s < 32; s++) begin
         if (bitv > v) begin
            bitv = bitv >> 2;
         end
      end
      for (int s = 0; s < 32; s++) begin
         if (bitv != '0) begin
            if (v >= res + bitv) begin
               v   = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
      end
      return res;
   endfunction

   // Factors 2^(2^-j) in Q2.30 for j = 1..24, each from the previous one.
   function automatic factor_tab_type exp2_factors();
      factor_tab_type tab;
      logic [63:0]    f;
      f = 64'h8000_0000;
      for (int j = 0; j < LOG_FRAC_W; j++) begin
         f      = isqrt64(f << 30);
         tab[j] = f[31:0];
      end
      return tab;
   endfunction

   localparam factor_tab_type EXP2_FACTOR = exp2_factors();

endpackage

>>> sv/cascade_split_distances.sv
// Top level of the cascade split distance block: sequencer, digit-serial
// multiplier, bit-serial divider and output register. Uses csd_pkg.
//
//  Channel   Direction  Handshake            Payload
//  req_      in         req_tvalid/tready    tdata: near, far, count, weight
//  rsp_      out        rsp_tvalid/tready    tdata: index, split; tlast: last split
//
// A request is worked through as the two logarithms and the shared exp2,
// then, for each cascade below the clamped count, an exp2 and divisions
// (exp2 iterations on the digit-serial multiplier and the 80-step division
// set most of the work).
// Reset is synchronous and active high; it clears the sequencer and the
// output valid flag. A result waits in the output register while the next
// cascade is computed; the sequencer stalls only when that register is full.
module cascade_split_distances
   import csd_pkg::*;
#(
   parameter int MAX_CASCADES = MAX_CASCADES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // near_dist[31:0], far_dist[63:32], cascade_total[71:64], blend_weight[88:72]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // cascade_index[2:0], split_value[19:3]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam logic [CNT_W-1:0]   LAST_IDX = CNT_W'(MAX_CASCADES - 1);
   localparam logic [COUNT_W-1:0] MAX_CNT  = COUNT_W'(MAX_CASCADES);

   typedef enum logic [13:0] {
      ST_IDLE      = 14'b00000000000001,
      ST_NORM      = 14'b00000000000010,
      ST_SQR_WAIT  = 14'b00000000000100,
      ST_EXP_STEP  = 14'b00000000001000,
      ST_EXP_WAIT  = 14'b00000000010000,
      ST_EXP_DONE  = 14'b00000000100000,
      ST_CASC      = 14'b00000001000000,
      ST_PUNI_WAIT = 14'b00000010000000,
      ST_E_WAIT    = 14'b00000100000000,
      ST_SHIFT     = 14'b00001000000000,
      ST_LN_WAIT   = 14'b00010000000000,
      ST_MIX       = 14'b00100000000000,
      ST_EMIT      = 14'b01000000000000,
      ST_SPARE     = 14'b10000000000000
   } state_type;

   // Sequencer registers.
   state_type            state_ff, state_in;
   logic [DIST_W-1:0]    near_ff, near_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [FRAC_W-1:0]    wgt_ff, wgt_in;
   logic [31:0]          x_ff, x_in;
   logic [4:0]           sh_ff, sh_in;
   logic [LOG_FRAC_W-1:0] frac_ff, frac_in;
   logic [4:0]           step_ff, step_in;
   logic                 log_sel_ff, log_sel_in;
   logic [31:0]          lf_ff, lf_in;
   logic [31:0]          d_ff, d_in;
   logic [4:0]           k_ff, k_in;
   logic [LOG_FRAC_W-1:0] efrac_ff, efrac_in;
   logic [31:0]          res_ff, res_in;
   logic                 exp_sel_ff, exp_sel_in;
   logic [62:0]          den_ff, den_in;
   logic                 den_zero_ff, den_zero_in;
   logic [62:0]          num_ff, num_in;
   logic [62:0]          dw_ff, dw_in;
   logic [CNT_W-1:0]     i_ff, i_in;
   logic [FRAC_W-1:0]    puni_ff, puni_in;
   logic [FRAC_W-1:0]    ln_ff, ln_in;
   logic [FRAC_W-1:0]    split_ff, split_in;
   logic [FRAC_W-1:0]    prev_ff, prev_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic [FRAC_W-1:0]    rsp_split_ff, rsp_split_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Multiplier.
   logic [MUL_W-1:0]     mul_a_ff, mul_a_in;
   logic [MUL_W-1:0]     mul_b_ff, mul_b_in;
   logic [2*MUL_W-1:0]   mul_acc_ff, mul_acc_in;
   logic [MUL_CNT_W-1:0] mul_cnt_ff, mul_cnt_in;
   logic                 mul_start;
   logic [MUL_W-1:0]     mul_ld_a, mul_ld_b;
   logic                 mul_done;
   logic [MUL_W+MUL_DIGIT-1:0] mul_pp;

   // Divider.
   logic [DIV_W-1:0]     div_dvd_ff, div_dvd_in;
   logic [DVS_W-1:0]     div_dvs_ff, div_dvs_in;
   logic [DVS_W-1:0]     div_rem_ff, div_rem_in;
   logic [Q_W-1:0]       div_q_ff, div_q_in;
   logic                 div_ovf_ff, div_ovf_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 div_start;
   logic [DIV_W-1:0]     div_ld_dvd;
   logic [DVS_W-1:0]     div_ld_dvs;
   logic [DIV_CNT_W-1:0] div_ld_len;
   logic                 div_done;
   logic [DVS_W:0]       div_trial, div_diff;
   logic                 div_ge;

   // Request field decode and clamping.
   logic [DIST_W-1:0]    req_near, req_far, near_lo, near_c, far_min, far_c;
   logic [COUNT_W-1:0]   req_cnt;
   logic [CNT_W-1:0]     cnt_c;
   logic [FRAC_W-1:0]    req_wgt, wgt_c;

   // Datapath helpers.
   logic [31:0]          sq_x;
   logic [LOG_FRAC_W-1:0] sq_frac;
   logic [31:0]          log_val;
   logic [31:0]          d_new;
   logic [62:0]          exp_shift, exp_val;
   logic [CNT_W-1:0]     i_inc;
   logic [35:0]          e_dvd;
   logic signed [17:0]   mix_diff;
   logic signed [35:0]   mix_prod;
   logic signed [37:0]   mix_sum;
   logic [19:0]          mix_q;
   logic [FRAC_W-1:0]    mix_sat;
   logic [FRAC_W-1:0]    emit_split;
   logic                 out_free;

   assign req_near = req_tdata[31:0];
   assign req_far  = req_tdata[63:32];
   assign req_cnt  = req_tdata[71:64];
   assign req_wgt  = req_tdata[88:72];

   // Near is held inside 7 .. 0xFFFFFFF8 so that near plus the margin fits.
   assign near_lo = (req_near < NEAR_MIN) ? NEAR_MIN : req_near;
   assign near_c  = (near_lo > NEAR_MAX) ? NEAR_MAX : near_lo;
   assign far_min = near_c + FAR_MARGIN;
   assign far_c   = (req_far < far_min) ? far_min : req_far;
   assign cnt_c   = (req_cnt == '0) ? CNT_W'(1) :
                    ((req_cnt > MAX_CNT) ? CNT_W'(MAX_CASCADES) : req_cnt[CNT_W-1:0]);
   assign wgt_c   = (req_wgt > SPLIT_ONE) ? SPLIT_ONE : req_wgt;

   // One squaring step of the log2 mantissa: the product is in Q2.62, and a
   // carry into the top bit yields a one in the fraction and a halved mantissa.
   assign sq_x    = mul_acc_ff[63] ? mul_acc_ff[63:32] : mul_acc_ff[62:31];
   assign sq_frac = {frac_ff[LOG_FRAC_W-2:0], mul_acc_ff[63]};
   assign log_val = {3'b000, 5'd31 - sh_ff, sq_frac};
   assign d_new   = lf_ff - log_val;

   assign exp_shift = 63'(res_ff) << k_ff;
   assign exp_val   = exp_shift - 63'(32'h4000_0000);

   assign i_inc = i_ff + CNT_W'(1);
   assign e_dvd = 36'(d_ff) * 36'(i_inc);

   // Blend: w*L + (1-w)*P written as P + w*(L-P), rounded to Q1.16.
   assign mix_diff = $signed({1'b0, ln_ff}) - $signed({1'b0, puni_ff});
   assign mix_prod = $signed({1'b0, wgt_ff}) * mix_diff;
   assign mix_sum  = $signed({5'b00000, puni_ff, 16'h0000}) + 38'(mix_prod)
                     + 38'sd32768;
   assign mix_q    = mix_sum[35:16];
   assign mix_sat  = (mix_q > 20'(SPLIT_ONE)) ? SPLIT_ONE : mix_q[FRAC_W-1:0];

   assign emit_split = (split_ff < prev_ff) ? prev_ff : split_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign mul_done = (mul_cnt_ff == '0);
   assign div_done = (div_cnt_ff == '0);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_split_ff, rsp_idx_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      near_in      = near_ff;
      cnt_in       = cnt_ff;
      wgt_in       = wgt_ff;
      x_in         = x_ff;
      sh_in        = sh_ff;
      frac_in      = frac_ff;
      step_in      = step_ff;
      log_sel_in   = log_sel_ff;
      lf_in        = lf_ff;
      d_in         = d_ff;
      k_in         = k_ff;
      efrac_in     = efrac_ff;
      res_in       = res_ff;
      exp_sel_in   = exp_sel_ff;
      den_in       = den_ff;
      den_zero_in  = den_zero_ff;
      num_in       = num_ff;
      dw_in        = dw_ff;
      i_in         = i_ff;
      puni_in      = puni_ff;
      ln_in        = ln_ff;
      split_in     = split_ff;
      prev_in      = prev_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_split_in = rsp_split_ff;
      rsp_last_in  = rsp_last_ff;
      mul_start    = 1'b0;
      mul_ld_a     = x_ff;
      mul_ld_b     = x_ff;
      div_start    = 1'b0;
      div_ld_dvd   = '0;
      div_ld_dvs   = DVS_W'(cnt_ff);
      div_ld_len   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               near_in    = near_c;
               x_in       = far_c;
               sh_in      = '0;
               log_sel_in = 1'b0;
               cnt_in     = cnt_c;
               wgt_in     = wgt_c;
               prev_in    = '0;
               i_in       = '0;
               state_in   = ST_NORM;
            end
         end
         ST_NORM: begin
            // Shift the operand up one bit a cycle until its top bit is set.
            if (x_ff[31]) begin
               frac_in   = '0;
               step_in   = '0;
               mul_start = 1'b1;
               state_in  = ST_SQR_WAIT;
            end else begin
               x_in  = {x_ff[30:0], 1'b0};
               sh_in = sh_ff + 5'd1;
            end
         end
         ST_SQR_WAIT: begin
            if (mul_done) begin
               x_in    = sq_x;
               frac_in = sq_frac;
               if (step_ff == 5'(LOG_FRAC_W - 1)) begin
                  if (!log_sel_ff) begin
                     lf_in      = log_val;
                     x_in       = near_ff;
                     sh_in      = '0;
                     log_sel_in = 1'b1;
                     state_in   = ST_NORM;
                  end else begin
                     d_in       = d_new;
                     k_in       = d_new[28:24];
                     efrac_in   = d_new[LOG_FRAC_W-1:0];
                     res_in     = 32'h4000_0000;
                     step_in    = '0;
                     exp_sel_in = 1'b0;
                     state_in   = ST_EXP_STEP;
                  end
               end else begin
                  step_in   = step_ff + 5'd1;
                  mul_start = 1'b1;
                  mul_ld_a  = sq_x;
                  mul_ld_b  = sq_x;
               end
            end
         end
         ST_EXP_STEP: begin
            // Fraction bits are taken from the top; a one multiplies in its factor.
            if (step_ff == 5'(LOG_FRAC_W)) begin
               state_in = ST_EXP_DONE;
            end else if (efrac_ff[LOG_FRAC_W-1]) begin
               mul_start = 1'b1;
               mul_ld_a  = res_ff;
               mul_ld_b  = EXP2_FACTOR[step_ff];
               state_in  = ST_EXP_WAIT;
            end else begin
               step_in  = step_ff + 5'd1;
               efrac_in = {efrac_ff[LOG_FRAC_W-2:0], 1'b0};
            end
         end
         ST_EXP_WAIT: begin
            if (mul_done) begin
               res_in   = mul_acc_ff[61:30];
               step_in  = step_ff + 5'd1;
               efrac_in = {efrac_ff[LOG_FRAC_W-2:0], 1'b0};
               state_in = ST_EXP_STEP;
            end
         end
         ST_EXP_DONE: begin
            if (!exp_sel_ff) begin
               den_in      = exp_val;
               den_zero_in = (exp_val == '0);
               state_in    = ST_CASC;
            end else begin
               num_in   = exp_val;
               dw_in    = den_ff;
               state_in = ST_SHIFT;
            end
         end
         ST_CASC: begin
            if (i_ff >= cnt_ff) begin
               split_in = SPLIT_ONE;
               state_in = ST_EMIT;
            end else begin
               div_start  = 1'b1;
               div_ld_dvd = {i_inc, 16'h0000, 60'h0};
               div_ld_len = DIV_CNT_W'(CNT_W + 16);
               state_in   = ST_PUNI_WAIT;
            end
         end
         ST_PUNI_WAIT: begin
            if (div_done) begin
               puni_in = div_q_ff[FRAC_W-1:0];
               if (den_zero_ff) begin
                  // A ratio this close to one takes the uniform split as its limit.
                  ln_in    = div_q_ff[FRAC_W-1:0];
                  state_in = ST_MIX;
               end else begin
                  div_start  = 1'b1;
                  div_ld_dvd = {e_dvd, 44'h0};
                  div_ld_len = DIV_CNT_W'(36);
                  state_in   = ST_E_WAIT;
               end
            end
         end
         ST_E_WAIT: begin
            if (div_done) begin
               k_in       = div_q_ff[28:24];
               efrac_in   = div_q_ff[LOG_FRAC_W-1:0];
               res_in     = 32'h4000_0000;
               step_in    = '0;
               exp_sel_in = 1'b1;
               state_in   = ST_EXP_STEP;
            end
         end
         ST_SHIFT: begin
            // Scale numerator and denominator together until the divisor fits.
            if (|dw_ff[62:DVS_W]) begin
               dw_in  = dw_ff >> 1;
               num_in = num_ff >> 1;
            end else begin
               div_start  = 1'b1;
               div_ld_dvd = {1'b0, num_ff, 16'h0000};
               div_ld_dvs = dw_ff[DVS_W-1:0];
               div_ld_len = DIV_CNT_W'(DIV_W);
               state_in   = ST_LN_WAIT;
            end
         end
         ST_LN_WAIT: begin
            if (div_done) begin
               if (div_ovf_ff || (div_q_ff > Q_W'(SPLIT_ONE))) begin
                  ln_in = SPLIT_ONE;
               end else begin
                  ln_in = div_q_ff[FRAC_W-1:0];
               end
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            split_in = mix_sat;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = i_ff[INDEX_W-1:0];
               rsp_split_in = emit_split;
               rsp_last_in  = (i_ff == LAST_IDX);
               prev_in      = emit_split;
               if (i_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in     = i_inc;
                  state_in = ST_CASC;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Multiplier: most significant digit of b first, accumulator shifts up.
   assign mul_pp = {{MUL_DIGIT{1'b0}}, mul_a_ff}
                   * (MUL_W + MUL_DIGIT)'(mul_b_ff[MUL_W-1 -: MUL_DIGIT]);

   always_comb begin
      mul_a_in   = mul_a_ff;
      mul_b_in   = mul_b_ff;
      mul_acc_in = mul_acc_ff;
      mul_cnt_in = mul_cnt_ff;
      if (mul_start) begin
         mul_a_in   = mul_ld_a;
         mul_b_in   = mul_ld_b;
         mul_acc_in = '0;
         mul_cnt_in = MUL_CNT_W'(MUL_STEPS);
      end else if (!mul_done) begin
         mul_acc_in = (mul_acc_ff << MUL_DIGIT) + (2*MUL_W)'(mul_pp);
         mul_b_in   = mul_b_ff << MUL_DIGIT;
         mul_cnt_in = mul_cnt_ff - MUL_CNT_W'(1);
      end
   end

   // Divider: restoring, one quotient bit a cycle; ones pushed past the top
   // of the quotient are remembered as overflow.
   assign div_trial = {div_rem_ff, div_dvd_ff[DIV_W-1]};
   assign div_diff  = div_trial - {1'b0, div_dvs_ff};
   assign div_ge    = (div_trial >= {1'b0, div_dvs_ff});

   always_comb begin
      div_dvd_in = div_dvd_ff;
      div_dvs_in = div_dvs_ff;
      div_rem_in = div_rem_ff;
      div_q_in   = div_q_ff;
      div_ovf_in = div_ovf_ff;
      div_cnt_in = div_cnt_ff;
      if (div_start) begin
         div_dvd_in = div_ld_dvd;
         div_dvs_in = div_ld_dvs;
         div_rem_in = '0;
         div_q_in   = '0;
         div_ovf_in = 1'b0;
         div_cnt_in = div_ld_len;
      end else if (!div_done) begin
         div_dvd_in = div_dvd_ff << 1;
         div_rem_in = div_ge ? div_diff[DVS_W-1:0] : div_trial[DVS_W-1:0];
         div_q_in   = {div_q_ff[Q_W-2:0], div_ge};
         div_ovf_in = div_ovf_ff | div_q_ff[Q_W-1];
         div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         i_ff         <= '0;
         mul_cnt_ff   <= '0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
         i_ff         <= i_in;
         mul_cnt_ff   <= mul_cnt_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      near_ff      <= near_in;
      cnt_ff       <= cnt_in;
      wgt_ff       <= wgt_in;
      x_ff         <= x_in;
      sh_ff        <= sh_in;
      frac_ff      <= frac_in;
      step_ff      <= step_in;
      log_sel_ff   <= log_sel_in;
      lf_ff        <= lf_in;
      d_ff         <= d_in;
      k_ff         <= k_in;
      efrac_ff     <= efrac_in;
      res_ff       <= res_in;
      exp_sel_ff   <= exp_sel_in;
      den_ff       <= den_in;
      den_zero_ff  <= den_zero_in;
      num_ff       <= num_in;
      dw_ff        <= dw_in;
      puni_ff      <= puni_in;
      ln_ff        <= ln_in;
      split_ff     <= split_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_split_ff <= rsp_split_in;
      rsp_last_ff  <= rsp_last_in;
      mul_a_ff     <= mul_a_in;
      mul_b_ff     <= mul_b_in;
      mul_acc_ff   <= mul_acc_in;
      div_dvd_ff   <= div_dvd_in;
      div_dvs_ff   <= div_dvs_in;
      div_rem_ff   <= div_rem_in;
      div_q_ff     <= div_q_in;
      div_ovf_ff   <= div_ovf_in;
   end

endmodule

>>> sv/csd_checker.sv
// Port-level checker for the cascade split block, bound to its top level.
// Uses csd_pkg for field widths and the value of one.
module csd_checker
   import csd_pkg::*;
#(
   parameter int MAX_CASCADES = MAX_CASCADES_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_split_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[19:3] <= SPLIT_ONE)
      else $error("split above one");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[2:0] == INDEX_W'(MAX_CASCADES - 1))
      else $error("last split on wrong cascade");

   a_busy_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |-> !req_tready)
      else $error("request taken in the middle of a run");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

endmodule

bind cascade_split_distances csd_checker #(
   .MAX_CASCADES(MAX_CASCADES)
) u_csd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

>>> test/cascade_split_distances_test.sv
// Self-checking testbench for the cascade split distance block.
// Predicts every split in fixed point and compares each result transfer.
// Depends on csd_pkg and cascade_split_distances.
`timescale 1ns / 1ps

module cascade_split_distances_test
   import csd_pkg::*;
();

   localparam int NCASC = MAX_CASCADES_DEF;

   typedef struct packed {
      logic [16:0] weight;
      logic [7:0]  count;
      logic [31:0] far_d;
      logic [31:0] near_d;
   } split_req_type;

   typedef struct {
      logic [2:0]  index;
      logic [16:0] split;
      logic        last;
   } split_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   split_req_type pending_reqs[$];
   split_rsp_type expected_splits[$];
   int            error_count = 0;
   int            send_idle_pct = 31;
   int            recv_idle_pct = 71;

   cascade_split_distances u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   // Truncated integer square root, bit by bit.
   function automatic logic [63:0] int_sqrt(input logic [63:0] value);
      logic [63:0] v, root, b;
      v = value;
      root = '0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= root + b) begin
            v = v - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   // log2 in Q8.24: top set bit plus a fraction from repeated squaring.
   function automatic logic [31:0] log2_fixed(input logic [31:0] x);
      logic [31:0] top, t, frac;
      logic [63:0] m;
      top = 0;
      t = x;
      frac = 0;
      while (t > 1) begin
         t = t >> 1;
         top++;
      end
      m = ({32'd0, x} << 31) >> top;
      for (int j = 23; j >= 0; j--) begin
         m = (m * m) >> 31;
         if (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            frac[j] = 1'b1;
         end
      end
      return (top << 24) | frac;
   endfunction

   // 2^e for e in Q8.24, result with 30 fraction bits.
   function automatic logic [63:0] exp2_fixed(input logic [63:0] e);
      logic [63:0] factor, acc;
      logic [4:0]  k;
      factor = 64'h8000_0000;
      acc = 64'h4000_0000;
      k = e[28:24];
      for (int j = 1; j <= 24; j++) begin
         factor = int_sqrt(factor << 30);
         if (e[24-j]) acc = (acc * factor) >> 30;
      end
      return acc << k;
   endfunction

   // Expected splits for one request, appended in cascade order.
   task automatic predict_splits(input split_req_type r);
      logic [31:0]   n, f, cnt, w, prev_split, split;
      logic [63:0]   d, den_full, puni, lognorm, e, num, den, mix;
      split_rsp_type s;
      n = r.near_d;
      f = r.far_d;
      cnt = 32'(r.count);
      w = 32'(r.weight);
      if (n < 7) n = 7;
      if (n > 32'hFFFF_FFF8) n = 32'hFFFF_FFF8;
      if (f < n + 7) f = n + 7;
      if (cnt < 1) cnt = 1;
      if (cnt > NCASC) cnt = NCASC;
      if (w > 65536) w = 65536;
      d = {32'd0, log2_fixed(f) - log2_fixed(n)};
      den_full = exp2_fixed(d) - 64'h4000_0000;
      prev_split = 0;
      for (int i = 0; i < NCASC; i++) begin
         split = 65536;
         if (i < cnt) begin
            puni = (64'(i + 1) << 16) / cnt;
            lognorm = puni;
            if (den_full != 0) begin
               e = d * (i + 1) / cnt;
               num = exp2_fixed(e) - 64'h4000_0000;
               den = den_full;
               while (den >= 64'h8000_0000_0000) begin
                  den = den >> 1;
                  num = num >> 1;
               end
               if (den != 0) begin
                  lognorm = (num << 16) / den;
                  if (lognorm > 65536) lognorm = 65536;
               end
            end
            mix = (64'(w) * lognorm + 64'(65536 - w) * puni + 32768) >> 16;
            if (mix > 65536) mix = 65536;
            split = mix[31:0];
         end
         if (split < prev_split) split = prev_split;
         prev_split = split & 32'h1FFFF;
         s.index = i[2:0];
         s.split = split[16:0];
         s.last = (i == NCASC - 1);
         expected_splits = {expected_splits, s};
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   // Appends one request to the queue the driver draws from.
   task automatic queue_req(input split_req_type r);
      pending_reqs = {pending_reqs, r};
   endtask

   // Driver: holds valid until the transfer, then takes the next item or idles.
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               split_req_type r;
               r = pending_reqs.pop_front();
               predict_splits(r);
               req_tdata <= REQ_DATA_W'(r);
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: compares each result transfer with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_splits.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
         end else begin
            split_rsp_type x;
            x = expected_splits.pop_front();
            if (rsp_tdata[2:0] !== x.index)
               report_mismatch($sformatf("index %0d, expected %0d", rsp_tdata[2:0], x.index));
            if (rsp_tdata[19:3] !== x.split)
               report_mismatch($sformatf("cascade %0d split %0d, expected %0d",
                                         x.index, rsp_tdata[19:3], x.split));
            if (rsp_tlast !== x.last)
               report_mismatch($sformatf("cascade %0d last %b", x.index, rsp_tlast));
         end
      end
   end

   function automatic split_req_type make_req(input logic [31:0] n, input logic [31:0] f,
                                              input logic [7:0] c, input logic [16:0] w);
      split_req_type r;
      r.near_d = n;
      r.far_d = f;
      r.count = c;
      r.weight = w;
      return r;
   endfunction

   // Mostly sensible camera ranges, with some raw full-range noise.
   function automatic split_req_type random_req();
      logic [31:0] n, f;
      logic [16:0] w;
      if ($urandom_range(9) < 2) begin
         n = $urandom;
         f = $urandom;
         w = 17'($urandom_range(131071));
         return make_req(n, f, 8'($urandom_range(255)), w);
      end
      n = $urandom_range(32'h0008_0000) >> $urandom_range(16);
      f = n + ($urandom >> $urandom_range(31));
      w = ($urandom_range(4) == 0) ? 17'd65536 : 17'($urandom_range(65536));
      return make_req(n, f, 8'($urandom_range(0, 6)), w);
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_tvalid || expected_splits.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes of every field and each special case.
      queue_req(make_req(0, 0, 0, 0));
      queue_req(make_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 17'h1FFFF));
      queue_req(make_req(32'h0000_0003, 32'hFFFF_FFFF, 4, 65536));
      queue_req(make_req(32'h0000_199A, 32'h03E8_0000, 4, 17'd32768));
      queue_req(make_req(32'h0001_0000, 32'h0000_0001, 2, 17'd65536));
      queue_req(make_req(32'h0001_0000, 32'h0001_0001, 3, 17'd40000));
      queue_req(make_req(32'h0001_0000, 32'h0001_0000, 4, 17'd65536));
      queue_req(make_req(32'hFFFF_FFF0, 32'hFFFF_FFFF, 1, 17'd65535));
      queue_req(make_req(32'h0000_0010, 32'h7FFF_FFFF, 5, 17'd1));
      queue_req(make_req(32'h0000_8000, 32'h0100_0000, 3, 17'h10001));
      queue_req(make_req(32'hAAAA_AAAA, 32'h5555_5555, 8'hAA, 17'h15555));
      queue_req(make_req(32'h5555_5555, 32'hAAAA_AAAA, 8'h55, 17'h0AAAA));
      for (int c = 0; c <= NCASC + 1; c++)
         queue_req(make_req(32'h0000_8000, 32'h0064_0000, 8'(c), 17'd49152));

      // Random, in three idling phases.
      for (int phase = 0; phase < 3; phase++) begin
         for (int k = 0; k < 32; k++) queue_req(random_req());
         wait_drained();
         send_idle_pct = (phase == 0) ? 71 : 0;
         recv_idle_pct = (phase == 0) ? 31 : 0;
      end
      repeat (50) @(posedge clock);

      if (error_count == 0) begin
         $display("[cascade_split_distances] OK");
      end else begin
         $display("[cascade_split_distances] ERROR");
      end
      $finish;
   end

   // Timeout for roughly 120 requests plus stalls, with margin.
   initial begin
      #40_000_000;
      $display("[cascade_split_distances] ERROR");
      $finish;
   end

endmodule
